[rtl/core/wav_stream_parser_assert.svh]
// assertion macros for the wav stream parser rtl
// depends on nothing; included inside module bodies after the logic
`ifndef WAV_STREAM_PARSER_ASSERT_SVH
`define WAV_STREAM_PARSER_ASSERT_SVH

// consequent checked in the same cycle
`define WSP_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wsp assertion failed");

// consequent checked in the cycle after the antecedent
`define WSP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wsp assertion failed");

`endif

[rtl/core/wsp_pkg.sv]
// types, tags and codes for the wav stream parser
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package wsp_pkg;

    // chunk and header tags as little-endian words
    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;
    localparam logic [31:0] FMT_MIN  = 32'd16;

    localparam logic [15:0] FMT_CODE_PCM  = 16'd1;
    localparam logic [31:0] FMT_BITS_16   = 32'd16;
    localparam logic [1:0]  CHAN_MONO     = 2'd1;
    localparam logic [1:0]  CHAN_STEREO   = 2'd2;
    localparam logic [2:0]  FRAME_STEREO  = 3'd4;

    typedef enum logic [3:0] {
        PH_RIFF  = 4'd0,
        PH_FSIZE = 4'd1,
        PH_WAVE  = 4'd2,
        PH_ID    = 4'd3,
        PH_SIZE  = 4'd4,
        PH_FMT   = 4'd5,
        PH_SKIP  = 4'd6,
        PH_DATA  = 4'd7
    } t_phase;

    typedef enum logic [1:0] {
        KIND_SAMPLE = 2'd0,
        KIND_EMPTY  = 2'd1,
        KIND_ERROR  = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        ERR_NONE     = 3'd0,
        ERR_NOT_RIFF = 3'd1,
        ERR_NOT_WAVE = 3'd2,
        ERR_FMT_SIZE = 3'd3,
        ERR_UNSUPP   = 3'd4,
        ERR_BAD_DATA = 3'd5,
        ERR_TRUNC    = 3'd6
    } t_err;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_flag;
    } t_in_item;

    typedef struct packed {
        logic               valid;
        t_kind              kind;
        logic signed [15:0] left_sample;
        logic signed [15:0] right_sample;
        logic               last_sample;
        t_err               error_code;
        logic [31:0]        rate_hz;
        logic [1:0]         channel_count;
    } t_result;

endpackage

[rtl/core/wav_stream_parser.sv]
// top level of the riff/wav 16-bit pcm stream parser
// depends on wsp_pkg, wsp_in_stage, wsp_parse_core, wsp_out_stage
//
//  channel  | dir | tdata                        | tuser      | tlast
//  ---------+-----+------------------------------+------------+------------
//  s (byte) | in  | data_byte[7:0]               | end_flag   | -
//  m (res)  | out | left, right, err, rate, chan | kind[1:0]  | last_sample
//
// one byte word is taken per clock while o_s_tready is high; a result passes from its
// accepted byte through the input register, parse logic and result register
// one 32-bit byte counter serves the fmt, skip and data phases, updated once per byte
// stalls on the result side propagate back one register to o_s_tready
// reset (synchronous, active low) clears handshake and parser state
// after an error, an empty data chunk or the final sample all further words are dropped silently
`timescale 1ns / 1ps

module wav_stream_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // byte stream in
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] data_byte
    input  logic        i_s_tuser,   // [0] end_flag
    // result stream out
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [71:0] o_m_tdata,   // [15:0] left_sample, [31:16] right_sample,
                                     // [34:32] error_code, [66:35] rate_hz,
                                     // [68:67] channel_count, [71:69] zero
    output logic [1:0]  o_m_tuser,   // [1:0] kind
    output logic        o_m_tlast    // last_sample
);
    import wsp_pkg::*;

    t_in_item s_item;
    t_in_item in_item;
    logic     in_valid;
    logic     out_space;
    logic     fire;
    t_result  core_res;
    t_result  out_res;

    assign s_item.data_byte = i_s_tdata;
    assign s_item.end_flag  = i_s_tuser;

    // a held byte is parsed whenever the result register can take its result
    assign fire = in_valid && out_space;

    wsp_in_stage u_in (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_tvalid),
        .o_ready   (o_s_tready),
        .i_item    (s_item),
        .i_advance (fire),
        .o_valid   (in_valid),
        .o_item    (in_item)
    );

    wsp_parse_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_item  (in_item),
        .o_res   (core_res)
    );

    wsp_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (fire && core_res.valid),
        .i_res   (core_res),
        .o_space (out_space),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_res   (out_res)
    );

    // pack payload lowest field first, padded to whole bytes
    assign o_m_tdata = {3'b000, out_res.channel_count, out_res.rate_hz,
                        out_res.error_code, out_res.right_sample, out_res.left_sample};
    assign o_m_tuser = out_res.kind;
    assign o_m_tlast = out_res.last_sample;

endmodule

[rtl/core/wsp_in_stage.sv]
// input register of the wav stream parser
// depends on wsp_pkg
`timescale 1ns / 1ps

module wsp_in_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  wsp_pkg::t_in_item i_item,
    input  logic              i_advance,
    output logic              o_valid,
    output wsp_pkg::t_in_item o_item
);
    import wsp_pkg::*;

    logic     r_valid;
    t_in_item r_item;

    assign o_ready = !r_valid || i_advance;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (i_advance) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

endmodule

[rtl/core/wsp_parse_core.sv]
// riff/wav parse state and per-byte next-state logic
// depends on wsp_pkg and wav_stream_parser_assert.svh
`timescale 1ns / 1ps

module wsp_parse_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  wsp_pkg::t_in_item i_item,
    output wsp_pkg::t_result  o_res
);
    import wsp_pkg::*;

    // byte offsets inside the 16-byte fmt body
    localparam logic [3:0] FO_CODE_LO = 4'd0;
    localparam logic [3:0] FO_CODE_HI = 4'd1;
    localparam logic [3:0] FO_CHAN_LO = 4'd2;
    localparam logic [3:0] FO_CHAN_HI = 4'd3;
    localparam logic [3:0] FO_RATE_0  = 4'd4;
    localparam logic [3:0] FO_RATE_1  = 4'd5;
    localparam logic [3:0] FO_RATE_2  = 4'd6;
    localparam logic [3:0] FO_RATE_3  = 4'd7;
    localparam logic [3:0] FO_BITS_LO = 4'd14;
    localparam logic [3:0] FO_BITS_HI = 4'd15;

    t_phase      r_phase,        n_phase;
    logic [31:0] r_byte_cnt,     n_byte_cnt;
    logic [31:0] r_word,         n_word;
    logic [31:0] r_chunk_len,    n_chunk_len;
    logic        r_fmt_seen,     n_fmt_seen;
    logic [1:0]  r_chan,         n_chan;
    logic [31:0] r_rate,         n_rate;
    logic [15:0] r_fmt_code,     n_fmt_code;
    logic [30:0] r_samples_left, n_samples_left;
    logic [2:0]  r_frame_bytes,  n_frame_bytes;
    logic        r_halted,       n_halted;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_RIFF;
            r_byte_cnt     <= '0;
            r_word         <= '0;
            r_chunk_len    <= '0;
            r_fmt_seen     <= 1'b0;
            r_chan         <= '0;
            r_rate         <= '0;
            r_fmt_code     <= '0;
            r_samples_left <= '0;
            r_frame_bytes  <= '0;
            r_halted       <= 1'b0;
        end else begin
            r_phase        <= n_phase;
            r_byte_cnt     <= n_byte_cnt;
            r_word         <= n_word;
            r_chunk_len    <= n_chunk_len;
            r_fmt_seen     <= n_fmt_seen;
            r_chan         <= n_chan;
            r_rate         <= n_rate;
            r_fmt_code     <= n_fmt_code;
            r_samples_left <= n_samples_left;
            r_frame_bytes  <= n_frame_bytes;
            r_halted       <= n_halted;
        end
    end

    always_comb begin
        logic [7:0]  v_b;
        logic [31:0] v_word_in;
        logic [1:0]  v_cnt2;
        logic        v_done;
        logic [3:0]  v_fidx;
        logic [31:0] v_w16;
        logic [2:0]  v_dcnt;
        logic [31:0] v_dword;
        logic [30:0] v_sl;
        logic        v_mis;
        logic        v_fail;
        t_err        v_code;

        v_b       = i_item.data_byte;
        v_word_in = {v_b, r_word[31:8]};
        v_cnt2    = r_byte_cnt[1:0] + 2'd1;
        v_done    = (v_cnt2 == 2'd0);
        v_fidx    = r_byte_cnt[3:0];
        v_w16     = {16'd0, v_b, r_word[7:0]};
        v_dcnt    = {1'b0, r_byte_cnt[1:0]} + 3'd1;
        v_dword   = r_word | ({24'd0, v_b} << {r_byte_cnt[1:0], 3'b000});
        v_sl      = (r_samples_left != '0) ? r_samples_left - 31'd1 : '0;
        v_mis     = (r_chan == CHAN_STEREO) ? |v_word_in[1:0] : v_word_in[0];
        v_fail    = 1'b0;
        v_code    = ERR_NONE;

        n_phase        = r_phase;
        n_byte_cnt     = r_byte_cnt;
        n_word         = r_word;
        n_chunk_len    = r_chunk_len;
        n_fmt_seen     = r_fmt_seen;
        n_chan         = r_chan;
        n_rate         = r_rate;
        n_fmt_code     = r_fmt_code;
        n_samples_left = r_samples_left;
        n_frame_bytes  = r_frame_bytes;
        n_halted       = r_halted;

        o_res               = '0;
        o_res.kind          = KIND_SAMPLE;
        o_res.error_code    = ERR_NONE;
        o_res.rate_hz       = r_rate;
        o_res.channel_count = r_chan;

        if (i_fire && !r_halted) begin
            if (i_item.end_flag) begin
                v_fail = 1'b1;
                v_code = ERR_TRUNC;
            end else begin
                unique case (r_phase)
                    PH_RIFF: begin
                        n_word     = v_word_in;
                        n_byte_cnt = {30'd0, v_cnt2};
                        if (v_done) begin
                            if (v_word_in != TAG_RIFF) begin
                                v_fail = 1'b1;
                                v_code = ERR_NOT_RIFF;
                            end else begin
                                n_phase = PH_FSIZE;
                            end
                        end
                    end
                    PH_FSIZE: begin
                        n_word     = v_word_in;
                        n_byte_cnt = {30'd0, v_cnt2};
                        if (v_done) begin
                            n_phase = PH_WAVE;
                        end
                    end
                    PH_WAVE: begin
                        n_word     = v_word_in;
                        n_byte_cnt = {30'd0, v_cnt2};
                        if (v_done) begin
                            if (v_word_in != TAG_WAVE) begin
                                v_fail = 1'b1;
                                v_code = ERR_NOT_WAVE;
                            end else begin
                                n_phase = PH_ID;
                            end
                        end
                    end
                    PH_ID: begin
                        n_word     = v_word_in;
                        n_byte_cnt = {30'd0, v_cnt2};
                        // chunk id parks in the length register until the size is in
                        if (v_done) begin
                            n_chunk_len = v_word_in;
                            n_phase     = PH_SIZE;
                        end
                    end
                    PH_SIZE: begin
                        n_word     = v_word_in;
                        n_byte_cnt = {30'd0, v_cnt2};
                        if (v_done) begin
                            n_chunk_len = v_word_in;
                            if (r_chunk_len == TAG_FMT) begin
                                if (r_fmt_seen || (v_word_in < FMT_MIN)) begin
                                    v_fail = 1'b1;
                                    v_code = ERR_FMT_SIZE;
                                end else begin
                                    n_fmt_seen = 1'b1;
                                    n_rate     = '0;
                                    n_fmt_code = '0;
                                    n_chan     = '0;
                                    n_byte_cnt = '0;
                                    n_phase    = PH_FMT;
                                end
                            end else if (r_chunk_len == TAG_DATA) begin
                                if (!r_fmt_seen) begin
                                    v_fail = 1'b1;
                                    v_code = ERR_TRUNC;
                                end else if (((r_chan != CHAN_MONO) &&
                                              (r_chan != CHAN_STEREO)) || v_mis) begin
                                    v_fail = 1'b1;
                                    v_code = ERR_BAD_DATA;
                                end else if (v_word_in == '0) begin
                                    n_halted   = 1'b1;
                                    o_res.valid = 1'b1;
                                    o_res.kind  = KIND_EMPTY;
                                end else begin
                                    n_frame_bytes  = {r_chan, 1'b0};
                                    n_samples_left = (r_chan == CHAN_STEREO) ?
                                                     {1'b0, v_word_in[31:2]} :
                                                     v_word_in[31:1];
                                    n_byte_cnt     = '0;
                                    n_word         = '0;
                                    n_phase        = PH_DATA;
                                end
                            end else begin
                                n_byte_cnt = v_word_in;
                                n_phase    = (v_word_in == '0) ? PH_ID : PH_SKIP;
                            end
                        end
                    end
                    PH_FMT: begin
                        n_byte_cnt = {28'd0, v_fidx + 4'd1};
                        unique case (v_fidx)
                            FO_CODE_LO: n_fmt_code = {8'd0, v_b};
                            FO_CODE_HI: n_fmt_code = {v_b, r_fmt_code[7:0]};
                            FO_CHAN_LO, FO_BITS_LO: n_word = {24'd0, v_b};
                            FO_CHAN_HI: begin
                                n_word = v_w16;
                                n_chan = ((v_w16 == {30'd0, CHAN_MONO}) ||
                                          (v_w16 == {30'd0, CHAN_STEREO})) ?
                                         v_w16[1:0] : 2'd0;
                            end
                            FO_RATE_0, FO_RATE_1, FO_RATE_2, FO_RATE_3: begin
                                n_rate = r_rate | ({24'd0, v_b} << {v_fidx[1:0], 3'b000});
                            end
                            FO_BITS_HI: begin
                                n_word = v_w16;
                                if ((r_fmt_code != FMT_CODE_PCM) || (v_w16 != FMT_BITS_16) ||
                                    (r_chan == 2'd0)) begin
                                    v_fail = 1'b1;
                                    v_code = ERR_UNSUPP;
                                end else begin
                                    n_word = '0;
                                    if (r_chunk_len > FMT_MIN) begin
                                        n_byte_cnt = r_chunk_len - FMT_MIN;
                                        n_phase    = PH_SKIP;
                                    end else begin
                                        n_byte_cnt = '0;
                                        n_phase    = PH_ID;
                                    end
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                    PH_SKIP: begin
                        n_byte_cnt = (r_byte_cnt != '0) ? r_byte_cnt - 32'd1 : '0;
                        if (n_byte_cnt == '0) begin
                            n_word  = '0;
                            n_phase = PH_ID;
                        end
                    end
                    PH_DATA: begin
                        if (v_dcnt < r_frame_bytes) begin
                            n_word     = v_dword;
                            n_byte_cnt = {29'd0, v_dcnt};
                        end else begin
                            n_word             = '0;
                            n_byte_cnt         = '0;
                            n_samples_left     = v_sl;
                            o_res.valid        = 1'b1;
                            o_res.kind         = KIND_SAMPLE;
                            o_res.left_sample  = v_dword[15:0];
                            o_res.right_sample = (r_frame_bytes == FRAME_STEREO) ?
                                                 v_dword[31:16] : v_dword[15:0];
                            if (v_sl == '0) begin
                                o_res.last_sample = 1'b1;
                                n_halted          = 1'b1;
                            end
                        end
                    end
                    default: begin
                        v_fail = 1'b1;
                        v_code = ERR_TRUNC;
                    end
                endcase
            end
        end

        // an error outranks anything set above and freezes the parser
        if (v_fail) begin
            n_halted            = 1'b1;
            o_res               = '0;
            o_res.valid         = 1'b1;
            o_res.kind          = KIND_ERROR;
            o_res.error_code    = v_code;
        end
    end

`include "wav_stream_parser_assert.svh"

    `WSP_ASSERT_SAME(a_halt_silent, i_clk, i_rst_n, r_halted, !o_res.valid)
    `WSP_ASSERT_NEXT(a_err_halts, i_clk, i_rst_n,
                     o_res.valid && (o_res.kind == KIND_ERROR), r_halted)
    `WSP_ASSERT_NEXT(a_last_halts, i_clk, i_rst_n, o_res.valid && o_res.last_sample, r_halted)
    `WSP_ASSERT_SAME(a_frame_ok, i_clk, i_rst_n, r_phase == PH_DATA,
                     (r_frame_bytes == 3'd2) || (r_frame_bytes == FRAME_STEREO))
    `WSP_ASSERT_SAME(a_left_nonzero, i_clk, i_rst_n,
                     (r_phase == PH_DATA) && !r_halted, r_samples_left != '0)

endmodule

[rtl/core/wsp_out_stage.sv]
// result register of the wav stream parser
// depends on wsp_pkg
`timescale 1ns / 1ps

module wsp_out_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  wsp_pkg::t_result i_res,
    output logic             o_space,
    output logic             o_valid,
    input  logic             i_ready,
    output wsp_pkg::t_result o_res
);
    import wsp_pkg::*;

    logic    r_valid;
    t_result r_res;

    assign o_space = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

endmodule

[tb/testbench.sv]
// self-checking bench for wav_stream_parser: builds one riff/wav byte stream per seed,
// predicts every result word in step with the byte handshake and checks the result stream
// depends on wsp_pkg (tags, kinds, error codes, result struct) and the rtl top level
`timescale 1ns / 1ps

module testbench;
    import wsp_pkg::*;

    // which way the stream is broken, if at all
    typedef enum int {
        FAULT_NONE,
        FAULT_TRUNC_DATA,
        FAULT_EMPTY_DATA,
        FAULT_ODD_DATA,
        FAULT_RIFF,
        FAULT_WAVE,
        FAULT_FMT_SHORT,
        FAULT_FMT_REPEAT,
        FAULT_FMT_CODE,
        FAULT_FMT_BITS,
        FAULT_FMT_CHANS,
        FAULT_NO_FMT,
        FAULT_EOS_SKIP,
        FAULT_EOS_BOUNDARY
    } t_fault;

    typedef struct packed {
        logic [7:0] data;
        logic       eos;
    } t_file_byte;

    localparam int QUIET_FROM = 600;
    localparam int QUIET_TO   = 1000;

    logic        i_clk;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata  = 8'd0;
    logic        i_s_tuser  = 1'b0;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [71:0] o_m_tdata;
    logic [1:0]  o_m_tuser;
    logic        o_m_tlast;

    wav_stream_parser u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    t_file_byte  file_bytes[$];
    t_result     predicted[$];
    t_fault      fault;
    logic [15:0] corner_vals [4] = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF};

    int  cycle_no    = 0;
    int  words_sent  = 0;
    int  drain_at    = -1;
    int  bytes_fed   = 0;
    int  results_got = 0;
    int  samples_got = 0;
    int  mismatches  = 0;
    bit  word_taken  = 1'b0;

    // parser image
    t_phase      cur_phase;
    logic [31:0] byte_index;
    logic [31:0] assembled;
    logic [31:0] chunk_size;
    bit          fmt_done;
    logic [1:0]  chan_cnt;
    logic [31:0] sample_rate;
    logic [15:0] fmt_code;
    logic [30:0] frames_left;
    logic [23:0] frame_size;
    bit          stopped;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------ prediction

    task automatic post_result(input t_kind k, input logic [15:0] l, input logic [15:0] r,
                               input logic last, input t_err e);
        t_result res;
        res.valid         = 1'b1;
        res.kind          = k;
        res.left_sample   = l;
        res.right_sample  = r;
        res.last_sample   = last;
        res.error_code    = e;
        res.rate_hz       = (k == KIND_ERROR) ? 32'd0 : sample_rate;
        res.channel_count = (k == KIND_ERROR) ? 2'd0 : chan_cnt;
        predicted.push_back(res);
    endtask

    task automatic raise_error(input t_err e);
        stopped = 1'b1;
        post_result(KIND_ERROR, 16'd0, 16'd0, 1'b0, e);
    endtask

    // little-endian word assembly, true once four bytes are in
    function automatic bit shift_in(input logic [7:0] b);
        assembled  = {b, assembled[31:8]};
        byte_index = (byte_index + 32'd1) & 32'd3;
        return byte_index == 32'd0;
    endfunction

    task automatic parse_file_byte(input logic [7:0] b, input logic eos);
        logic [31:0] id;
        logic [31:0] quot;
        logic [3:0]  idx;
        logic [1:0]  slot;
        logic [15:0] lv;
        logic [15:0] rv;
        if (stopped) return;
        if (eos) begin
            raise_error(ERR_TRUNC);
            return;
        end
        case (cur_phase)
            PH_RIFF: begin
                if (shift_in(b)) begin
                    if (assembled != TAG_RIFF) raise_error(ERR_NOT_RIFF);
                    else cur_phase = PH_FSIZE;
                end
            end
            PH_FSIZE: begin
                if (shift_in(b)) cur_phase = PH_WAVE;
            end
            PH_WAVE: begin
                if (shift_in(b)) begin
                    if (assembled != TAG_WAVE) raise_error(ERR_NOT_WAVE);
                    else cur_phase = PH_ID;
                end
            end
            PH_ID: begin
                // the id waits in chunk_size until the size word is in
                if (shift_in(b)) begin
                    chunk_size = assembled;
                    cur_phase  = PH_SIZE;
                end
            end
            PH_SIZE: begin
                id = chunk_size;
                if (shift_in(b)) begin
                    chunk_size = assembled;
                    if (id == TAG_FMT) begin
                        if (fmt_done || chunk_size < FMT_MIN) raise_error(ERR_FMT_SIZE);
                        else begin
                            fmt_done    = 1'b1;
                            sample_rate = 32'd0;
                            fmt_code    = 16'd0;
                            chan_cnt    = 2'd0;
                            byte_index  = 32'd0;
                            cur_phase   = PH_FMT;
                        end
                    end else if (id == TAG_DATA) begin
                        if (!fmt_done) raise_error(ERR_TRUNC);
                        else begin
                            frame_size = {21'd0, chan_cnt, 1'b0};
                            if (frame_size == 24'd0) raise_error(ERR_BAD_DATA);
                            else if (chunk_size % {8'd0, frame_size} != 32'd0) begin
                                raise_error(ERR_BAD_DATA);
                            end else if (chunk_size == 32'd0) begin
                                stopped = 1'b1;
                                post_result(KIND_EMPTY, 16'd0, 16'd0, 1'b0, ERR_NONE);
                            end else begin
                                quot        = chunk_size / {8'd0, frame_size};
                                frames_left = quot[30:0];
                                byte_index  = 32'd0;
                                assembled   = 32'd0;
                                cur_phase   = PH_DATA;
                            end
                        end
                    end else begin
                        // unknown chunk, skipped by its size with no pad byte
                        byte_index = chunk_size;
                        cur_phase  = (chunk_size == 32'd0) ? PH_ID : PH_SKIP;
                    end
                end
            end
            PH_FMT: begin
                idx = byte_index[3:0];
                if (idx == 4'd15) begin
                    assembled = assembled | {16'd0, b, 8'd0};
                    if (fmt_code != FMT_CODE_PCM || assembled != FMT_BITS_16 || chan_cnt == 2'd0)
                        raise_error(ERR_UNSUPP);
                    else begin
                        byte_index = 32'd0;
                        assembled  = 32'd0;
                        if (chunk_size > FMT_MIN) begin
                            byte_index = chunk_size - FMT_MIN;
                            cur_phase  = PH_SKIP;
                        end else cur_phase = PH_ID;
                    end
                end else begin
                    if (idx == 4'd0) fmt_code = {8'd0, b};
                    else if (idx == 4'd1) fmt_code = fmt_code | {b, 8'd0};
                    else if (idx == 4'd2 || idx == 4'd14) assembled = {24'd0, b};
                    else if (idx == 4'd3) begin
                        assembled = assembled | {16'd0, b, 8'd0};
                        chan_cnt  = (assembled == 32'd1 || assembled == 32'd2) ?
                                    assembled[1:0] : 2'd0;
                    end else if (idx >= 4'd4 && idx <= 4'd7)
                        sample_rate = sample_rate | ({24'd0, b} << (8 * (idx - 4'd4)));
                    byte_index = {28'd0, idx} + 32'd1;
                end
            end
            PH_SKIP: begin
                if (byte_index > 32'd0) byte_index = byte_index - 32'd1;
                if (byte_index == 32'd0) begin
                    assembled = 32'd0;
                    cur_phase = PH_ID;
                end
            end
            PH_DATA: begin
                slot       = byte_index[1:0];
                assembled  = assembled | ({24'd0, b} << (8 * slot));
                byte_index = {30'd0, slot} + 32'd1;
                if (byte_index >= {8'd0, frame_size}) begin
                    lv         = assembled[15:0];
                    rv         = (frame_size == 24'd4) ? assembled[31:16] : lv;
                    byte_index = 32'd0;
                    assembled  = 32'd0;
                    if (frames_left > 31'd0) frames_left = frames_left - 31'd1;
                    if (frames_left == 31'd0) begin
                        stopped = 1'b1;
                        post_result(KIND_SAMPLE, lv, rv, 1'b1, ERR_NONE);
                    end else post_result(KIND_SAMPLE, lv, rv, 1'b0, ERR_NONE);
                end
            end
            default: begin
                raise_error(ERR_TRUNC);
            end
        endcase
    endtask

    // ------------------------------------------------------------------ checking

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_result want;
        if (i_rst_n) begin
            cycle_no++;
            if (o_m_tvalid && i_m_tready) begin
                results_got++;
                if (o_m_tuser == KIND_SAMPLE) samples_got++;
                if (predicted.size() == 0) begin
                    $error("result word with nothing predicted: kind %0d", o_m_tuser);
                    mismatches++;
                end else begin
                    want = predicted.pop_front();
                    check_field("kind", {30'd0, want.kind}, {30'd0, o_m_tuser});
                    check_field("left_sample", {16'd0, want.left_sample},
                                {16'd0, o_m_tdata[15:0]});
                    check_field("right_sample", {16'd0, want.right_sample},
                                {16'd0, o_m_tdata[31:16]});
                    check_field("last_sample", {31'd0, want.last_sample}, {31'd0, o_m_tlast});
                    check_field("error_code", {29'd0, want.error_code},
                                {29'd0, o_m_tdata[34:32]});
                    check_field("rate_hz", want.rate_hz, o_m_tdata[66:35]);
                    check_field("channel_count", {30'd0, want.channel_count},
                                {30'd0, o_m_tdata[68:67]});
                end
            end
            word_taken = i_s_tvalid && o_s_tready;
            if (word_taken) begin
                bytes_fed++;
                parse_file_byte(i_s_tdata, i_s_tuser);
            end
        end else word_taken = 1'b0;
    end

    // ------------------------------------------------------------------ driving

    function automatic bit idle_now();
        if (cycle_no >= QUIET_FROM && cycle_no < QUIET_TO) return 1'b0;
        return $urandom_range(99) < 20;
    endfunction

    always @(negedge i_clk) begin : driver
        t_file_byte nxt;
        if (i_rst_n) begin
            if (!i_s_tvalid || word_taken) begin
                // at the marked word the sender holds off until nothing is outstanding
                if (file_bytes.size() != 0 && !(words_sent == drain_at && predicted.size() != 0)
                    && !idle_now()) begin
                    nxt = file_bytes.pop_front();
                    words_sent++;
                    i_s_tvalid <= 1'b1;
                    i_s_tdata  <= nxt.data;
                    i_s_tuser  <= nxt.eos;
                end else i_s_tvalid <= 1'b0;
            end
            i_m_tready <= !idle_now();
        end
    end

    // ------------------------------------------------------------------ stimulus

    task automatic put_byte(input logic [7:0] b);
        t_file_byte w;
        w.data = b;
        w.eos  = 1'b0;
        file_bytes.push_back(w);
    endtask

    task automatic put_le16(input logic [15:0] v);
        put_byte(v[7:0]);
        put_byte(v[15:8]);
    endtask

    task automatic put_le32(input logic [31:0] v);
        put_le16(v[15:0]);
        put_le16(v[31:16]);
    endtask

    task automatic put_end();
        t_file_byte w;
        w.data = 8'($urandom_range(255));
        w.eos  = 1'b1;
        file_bytes.push_back(w);
    endtask

    task automatic put_junk(input int unsigned len);
        logic [31:0] id;
        id = $urandom();
        if (id == TAG_FMT || id == TAG_DATA) id = ~id;
        put_le32(id);
        put_le32(len);
        repeat (len) put_byte(8'($urandom_range(255)));
    endtask

    function automatic logic [15:0] rand_sample();
        if ($urandom_range(7) == 0) return corner_vals[$urandom_range(3)];
        return 16'($urandom_range(65535));
    endfunction

    task automatic put_fmt(input int unsigned len, input logic [15:0] code,
                           input logic [15:0] chans, input logic [31:0] rate,
                           input logic [15:0] bits);
        put_le32(TAG_FMT);
        put_le32(len);
        put_le16(code);
        put_le16(chans);
        put_le32(rate);
        put_le32($urandom());
        put_le16(16'($urandom_range(65535)));
        put_le16(bits);
        if (len > 16) repeat (len - 16) put_byte(8'($urandom_range(255)));
    endtask

    initial begin : stimulus
        int unsigned pick, chans_sel, fb, frames, cut, total_data, guard, fmt_len;
        logic [31:0] rate_v, data_len, frame_word;
        logic [15:0] code_v, chan_v, bits_v, lv, rv;

        cur_phase   = PH_RIFF;
        byte_index  = 32'd0;
        assembled   = 32'd0;
        chunk_size  = 32'd0;
        fmt_done    = 1'b0;
        chan_cnt    = 2'd0;
        sample_rate = 32'd0;
        fmt_code    = 16'd0;
        frames_left = 31'd0;
        frame_size  = 24'd0;
        stopped     = 1'b0;

        pick = $urandom_range(99);
        if (pick < 55) fault = FAULT_NONE;
        else if (pick < 70) fault = FAULT_TRUNC_DATA;
        else if (pick < 75) fault = FAULT_EMPTY_DATA;
        else if (pick < 80) fault = FAULT_ODD_DATA;
        else fault = t_fault'(int'(FAULT_RIFF) + int'($urandom_range(9)));

        chans_sel = $urandom_range(1, 2);
        fb        = 2 * chans_sel;
        frames    = $urandom_range(1100, 1200) / fb;

        // file header
        put_le32(fault == FAULT_RIFF ? TAG_RIFF ^ (32'd1 << $urandom_range(31)) : TAG_RIFF);
        put_le32($urandom());
        put_le32(fault == FAULT_WAVE ? TAG_WAVE ^ (32'd1 << $urandom_range(31)) : TAG_WAVE);
        if (fault == FAULT_EOS_BOUNDARY) put_end();

        // chunks ahead of fmt: an empty one, one of odd or even length, plus faulty ones
        put_junk(0);
        if (fault == FAULT_EOS_SKIP) begin
            put_le32(32'h6B6E_756A);
            put_le32(32'd20);
            repeat ($urandom_range(1, 19)) put_byte(8'($urandom_range(255)));
            put_end();
        end
        put_junk($urandom_range(1, 23));
        if (fault == FAULT_NO_FMT) begin
            put_le32(TAG_DATA);
            put_le32(32'd4);
        end

        // format chunk, optionally with trailing bytes to skip
        case ($urandom_range(3))
            0:       rate_v = 32'd0;
            1:       rate_v = 32'hFFFF_FFFF;
            2:       rate_v = 32'd44100;
            default: rate_v = $urandom();
        endcase
        fmt_len = $urandom_range(1) ? 16 : $urandom_range(17, 23);
        if (fault == FAULT_FMT_SHORT) fmt_len = $urandom_range(15);
        code_v = FMT_CODE_PCM;
        if (fault == FAULT_FMT_CODE)
            code_v = $urandom_range(1) ? 16'd0 : 16'($urandom_range(2, 65535));
        chan_v = 16'(chans_sel);
        if (fault == FAULT_FMT_CHANS)
            chan_v = $urandom_range(1) ? 16'd0 : 16'($urandom_range(3, 65535));
        bits_v = 16'd16;
        if (fault == FAULT_FMT_BITS) bits_v = 16'd16 ^ (16'd1 << $urandom_range(15));
        put_fmt(fmt_len, code_v, chan_v, rate_v, bits_v);
        if (fault == FAULT_FMT_REPEAT) put_fmt(16, code_v, chan_v, rate_v, bits_v);
        put_junk($urandom_range(0, 9));

        // data chunk: corner samples first, then random content
        data_len = frames * fb;
        if (fault == FAULT_EMPTY_DATA) data_len = 32'd0;
        if (fault == FAULT_ODD_DATA) data_len = data_len + ((fb == 4) ? $urandom_range(1, 3) : 1);
        put_le32(TAG_DATA);
        put_le32(data_len);
        cut = $urandom_range(1, frames * fb - 1);
        total_data = 0;
        if (fault != FAULT_EMPTY_DATA) begin
            for (int unsigned f = 0; f < frames; f++) begin
                if (f < 4) begin
                    lv = corner_vals[f];
                    rv = corner_vals[3 - f];
                end else begin
                    lv = rand_sample();
                    rv = rand_sample();
                end
                frame_word = {rv, lv};
                if (f == frames / 2) drain_at = file_bytes.size();
                for (int k = 0; k < fb; k++) begin
                    put_byte(frame_word[8*k +: 8]);
                    total_data++;
                    if (fault == FAULT_TRUNC_DATA && total_data == cut) put_end();
                end
            end
        end
        // with no data bytes the sender still drains once before the tail
        if (drain_at < 0) drain_at = file_bytes.size();

        // trailing words land on a stopped parser and must produce nothing
        repeat ($urandom_range(2, 6)) put_byte(8'($urandom_range(255)));
        put_end();
        put_byte(8'($urandom_range(255)));

        repeat (6) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        while (file_bytes.size() != 0 || i_s_tvalid) @(posedge i_clk);
        guard = 0;
        while (predicted.size() != 0 && guard < 20000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (16) @(posedge i_clk);
        if (predicted.size() != 0) begin
            $error("%0d predicted result words never arrived", predicted.size());
            mismatches++;
        end

        $display("fed %0d file words, stream variant %s, %0d channel(s), fmt length %0d",
                 bytes_fed, fault.name(), chans_sel, fmt_len);
        $display("checked %0d result words, %0d of them samples", results_got, samples_got);
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin : watchdog
        #3_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

[files.f]
+incdir+rtl/core
rtl/core/wsp_pkg.sv
rtl/core/wsp_in_stage.sv
rtl/core/wsp_parse_core.sv
rtl/core/wsp_out_stage.sv
rtl/core/wav_stream_parser.sv
tb/testbench.sv
